@@ rtl/scored_register_allocator_top_defines.svh @@
// Assertion macros shared by the scored register allocator modules.
// Depends on nothing; the using module provides clk and rst_n.
`ifndef SCORED_REGISTER_ALLOCATOR_TOP_DEFINES_SVH
`define SCORED_REGISTER_ALLOCATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SRA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define SRA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ rtl/sra_pkg.sv @@
// Shared types and constants of the scored register allocator.
// Depends on nothing; used by the controller, datapath and top level.
package sra_pkg;

  // Default sizes.
  localparam int P_REG_COUNT  = 256;
  localparam int P_RESERVED   = 4;
  localparam int P_HOT_WINDOW = 32;

  // Fixed field widths.
  localparam int CNT_W = 9;

  // Command codes.
  localparam logic [2:0] CMD_ALLOC = 3'd0;
  localparam logic [2:0] CMD_FREE  = 3'd1;
  localparam logic [2:0] CMD_LOOP  = 3'd2;
  localparam logic [2:0] CMD_HOT   = 3'd3;
  localparam logic [2:0] CMD_SPILL = 3'd4;

  // Status codes.
  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_NONE   = 2'd1;
  localparam logic [1:0] ST_PINNED = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic scan_step;
    logic exec;
    logic load_out;
  } sra_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic scan_last;
    logic out_busy;
  } sra_stat_t;

endpackage

@@ rtl/sra_ctrl.sv @@
// Controller of the scored register allocator: sequences capture, scan, execute and output.
// Depends on sra_pkg and the assertion macro header.
`include "scored_register_allocator_top_defines.svh"

module sra_ctrl
  import sra_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [2:0] in_command,
  output logic       in_stall,
  input  sra_stat_t  stat,
  output sra_cmd_t   cmd
);

  typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SLAST, S_EXEC, S_DONE} state_t;

  state_t state_r;
  logic   accept;

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  // Command decode from the state.
  always_comb begin
    cmd           = '0;
    cmd.capture   = accept;
    cmd.scan_step = (state_r == S_SCAN);
    cmd.exec      = (state_r == S_EXEC);
    cmd.load_out  = (state_r == S_DONE) && !stat.out_busy;
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= (in_command == CMD_ALLOC) ? S_SCAN : S_EXEC;
          end
        end
        S_SCAN: begin
          if (stat.scan_last) state_r <= S_SLAST;
        end
        S_SLAST: state_r <= S_EXEC;
        S_EXEC:  state_r <= S_DONE;
        S_DONE: begin
          if (!stat.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  `SRA_ASSERT_NEXT(a_accept_leaves_idle, accept, state_r != S_IDLE, "accept did not leave idle")
  `SRA_ASSERT_NOW(a_load_only_done, cmd.load_out, state_r == S_DONE, "output load outside done")
  `SRA_ASSERT_NEXT(a_exec_to_done, state_r == S_EXEC, state_r == S_DONE, "execute not followed by done")

endmodule

@@ rtl/sra_dpath.sv @@
// Datapath of the scored register allocator: register table, score scan and counters.
// Depends on sra_pkg and the assertion macro header.
`include "scored_register_allocator_top_defines.svh"

module sra_dpath
  import sra_pkg::*;
#(
  parameter int REG_COUNT  = P_REG_COUNT,
  parameter int RESERVED   = P_RESERVED,
  parameter int HOT_WINDOW = P_HOT_WINDOW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  sra_cmd_t         cmd,
  output sra_stat_t        stat,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_reuse_enable,
  input  logic [2:0]       in_command,
  input  logic [7:0]       in_reg_index,
  input  logic             in_is_loop,
  input  logic [15:0]      in_lifetime,
  input  logic [7:0]       in_spill_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_chosen_reg,
  output logic [CNT_W-1:0] out_high_water,
  output logic [CNT_W-1:0] out_free_count,
  output logic [CNT_W-1:0] out_live_count
);

  localparam int IW = $clog2(REG_COUNT);
  localparam logic [CNT_W-1:0] N_CNT = CNT_W'(REG_COUNT);

  // Configuration register.
  logic reuse_r;
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reuse_r <= 1'b0;
    end else if (cfg_valid) begin
      reuse_r <= cfg_reuse_enable;
    end
  end

  // Captured request.
  logic [2:0] cmd_r;
  logic [7:0] reg_r;
  logic       loop_r;
  logic       life_nz_r;
  logic [7:0] spill_in_r;
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r      <= in_command;
      reg_r      <= in_reg_index;
      loop_r     <= in_is_loop;
      life_nz_r  <= (in_lifetime != 16'd0);
      spill_in_r <= in_spill_value;
    end
  end

  // Per-register flags and counters.
  logic [REG_COUNT-1:0] live_r, loopf_r, recent_r, spill_vld_r;
  logic [CNT_W-1:0]     high_r, avail_r, live_cnt_r;
  logic [7:0]           spill_mem [REG_COUNT];

  // Scan pipeline: address, registered read, then score compare.
  logic [IW-1:0]    scan_idx_r, idx_d_r, best_idx_r;
  logic             sv_r, best_found_r;
  logic [7:0]       spill_rd_r;
  logic signed [9:0] best_score_r, score;
  logic [7:0]       spill_eff;
  logic             eligible;

  assign stat.scan_last = (scan_idx_r == IW'(REG_COUNT - 1));
  assign spill_eff = spill_vld_r[idx_d_r] ? spill_rd_r : 8'd0;
  assign eligible  = !(32'(idx_d_r) < RESERVED) && !live_r[idx_d_r];

  always_comb begin
    score = 10'sd110 - $signed(10'(idx_d_r >> 2)) - $signed({2'b00, spill_eff});
    if (loop_r && loopf_r[idx_d_r])  score = score + 10'sd20;
    if (reuse_r && recent_r[idx_d_r]) score = score + 10'sd15;
  end

  always_ff @(posedge clk) begin
    spill_rd_r <= spill_mem[scan_idx_r];
    idx_d_r    <= scan_idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_idx_r   <= '0;
      sv_r         <= 1'b0;
      best_found_r <= 1'b0;
      best_score_r <= -10'sd1;
      best_idx_r   <= '0;
    end else begin
      sv_r <= cmd.scan_step;
      if (cmd.capture) begin
        scan_idx_r   <= '0;
        best_found_r <= 1'b0;
        best_score_r <= -10'sd1;
      end else begin
        if (cmd.scan_step) scan_idx_r <= scan_idx_r + 1'b1;
        if (sv_r && eligible && (score > best_score_r)) begin
          best_found_r <= 1'b1;
          best_score_r <= score;
          best_idx_r   <= idx_d_r;
        end
      end
    end
  end

  // Spill cost memory write.
  logic spill_wr;
  logic reg_ok;
  assign reg_ok   = (32'(reg_r) < REG_COUNT);
  assign spill_wr = cmd.exec && (cmd_r == CMD_SPILL) && reg_ok;
  always_ff @(posedge clk) begin
    if (spill_wr) spill_mem[reg_r[IW-1:0]] <= spill_in_r;
  end

  // Command execution.
  logic [1:0] res_status_r;
  logic [7:0] res_chosen_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r      <= '0;
      loopf_r     <= '0;
      recent_r    <= '0;
      spill_vld_r <= '0;
      high_r      <= '0;
      avail_r     <= CNT_W'(REG_COUNT - RESERVED);
      live_cnt_r  <= '0;
    end else if (cmd.exec) begin
      unique case (cmd_r)
        CMD_ALLOC: begin
          if (best_found_r) begin
            live_r[best_idx_r]  <= life_nz_r;
            loopf_r[best_idx_r] <= loop_r;
            if (life_nz_r) live_cnt_r <= live_cnt_r + 1'b1;
            if (CNT_W'(best_idx_r) + 1'b1 > high_r) high_r <= CNT_W'(best_idx_r) + 1'b1;
            if (avail_r != '0) avail_r <= avail_r - 1'b1;
            res_status_r <= ST_DONE;
            res_chosen_r <= 8'(best_idx_r);
          end else begin
            res_status_r <= ST_NONE;
            res_chosen_r <= 8'd0;
          end
        end
        CMD_FREE: begin
          res_chosen_r <= 8'd0;
          if (!reg_ok) begin
            res_status_r <= ST_NONE;
          end else if (32'(reg_r) < RESERVED) begin
            res_status_r <= ST_PINNED;
          end else begin
            res_status_r <= ST_DONE;
            live_r[reg_r[IW-1:0]]   <= 1'b0;
            recent_r[reg_r[IW-1:0]] <= 1'b1;
            if (live_r[reg_r[IW-1:0]]) live_cnt_r <= live_cnt_r - 1'b1;
            if (avail_r < N_CNT) avail_r <= avail_r + 1'b1;
          end
        end
        CMD_LOOP: begin
          res_status_r <= ST_DONE;
          res_chosen_r <= 8'd0;
          loopf_r      <= loopf_r | live_r;
        end
        CMD_HOT: begin
          res_status_r <= ST_DONE;
          res_chosen_r <= 8'd0;
          for (int i = 0; i < REG_COUNT; i++) begin
            if (i < HOT_WINDOW && live_r[i]) spill_vld_r[i] <= 1'b0;
          end
        end
        CMD_SPILL: begin
          res_chosen_r <= 8'd0;
          if (reg_ok) begin
            res_status_r <= ST_DONE;
            spill_vld_r[reg_r[IW-1:0]] <= 1'b1;
          end else begin
            res_status_r <= ST_NONE;
          end
        end
        default: begin
          res_status_r <= ST_DONE;
          res_chosen_r <= 8'd0;
        end
      endcase
    end
  end

  // Output register.
  logic out_valid_r;
  assign out_valid     = out_valid_r;
  assign stat.out_busy = out_valid_r && out_stall;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status     <= res_status_r;
      out_chosen_reg <= res_chosen_r;
      out_high_water <= high_r;
      out_free_count <= avail_r;
      out_live_count <= live_cnt_r;
    end
  end

  `SRA_ASSERT_NOW(a_live_cnt_bound, 1'b1, live_cnt_r <= N_CNT, "live count above register count")
  `SRA_ASSERT_NOW(a_avail_bound, 1'b1, avail_r <= N_CNT, "free count above register count")
  `SRA_ASSERT_NEXT(a_load_sets_valid, cmd.load_out, out_valid_r, "loaded result not presented")

endmodule

@@ rtl/scored_register_allocator_top.sv @@
// An allocate scans every register for a score, one register per cycle through the spill
// cost memory read port, then executes; other commands execute directly and go to the output.
// One request at a time: in_stall is high until the result is loaded into the output register.
// Reset (rst_n, synchronous, active low) clears the table through flag flip-flops and
// spill valid bits; registers below RESERVED come out of reset pinned.
// Top level of the scored register allocator; depends on sra_pkg, sra_ctrl, sra_dpath.
module scored_register_allocator_top
  import sra_pkg::*;
#(
  parameter int REG_COUNT  = P_REG_COUNT,
  parameter int RESERVED   = P_RESERVED,
  parameter int HOT_WINDOW = P_HOT_WINDOW
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic             cfg_reuse_enable,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [2:0]       in_command,
  input  logic [7:0]       in_reg_index,
  input  logic             in_is_loop,
  input  logic [15:0]      in_lifetime,
  input  logic [7:0]       in_spill_value,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [1:0]       out_status,
  output logic [7:0]       out_chosen_reg,
  output logic [CNT_W-1:0] out_high_water,
  output logic [CNT_W-1:0] out_free_count,
  output logic [CNT_W-1:0] out_live_count
);

  sra_cmd_t  cmd;
  sra_stat_t stat;

  // Request sequencing.
  sra_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .stat       (stat),
    .cmd        (cmd)
  );

  // Register table and scoring.
  sra_dpath #(
    .REG_COUNT  (REG_COUNT),
    .RESERVED   (RESERVED),
    .HOT_WINDOW (HOT_WINDOW)
  ) u_dpath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .stat             (stat),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_reuse_enable (cfg_reuse_enable),
    .in_command       (in_command),
    .in_reg_index     (in_reg_index),
    .in_is_loop       (in_is_loop),
    .in_lifetime      (in_lifetime),
    .in_spill_value   (in_spill_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_chosen_reg   (out_chosen_reg),
    .out_high_water   (out_high_water),
    .out_free_count   (out_free_count),
    .out_live_count   (out_live_count)
  );

endmodule

@@ tb/scored_register_allocator_top_tb.sv @@
// Self-checking testbench for scored_register_allocator_top. It holds its own model of the register table.
// The driver updates the model; the monitor checks every response. Depends on sra_pkg and the RTL.
module scored_register_allocator_top_tb;
  import sra_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NREG = P_REG_COUNT;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    logic [2:0]  command;
    logic [7:0]  reg_index;
    logic        is_loop;
    logic [15:0] lifetime;
    logic [7:0]  spill_value;
  } alloc_req_t;

  typedef struct {
    logic [1:0]       status;
    logic [7:0]       chosen_reg;
    logic [CNT_W-1:0] high_water;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] live_count;
  } alloc_resp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic cfg_reuse_enable = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [2:0] in_command = '0;
  logic [7:0] in_reg_index = '0;
  logic in_is_loop = 1'b0;
  logic [15:0] in_lifetime = '0;
  logic [7:0] in_spill_value = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_chosen_reg;
  logic [CNT_W-1:0] out_high_water;
  logic [CNT_W-1:0] out_free_count;
  logic [CNT_W-1:0] out_live_count;

  scored_register_allocator_top i_dut (.*);

  always #2 clk = ~clk;

  // Model copy of the register table.
  logic [15:0]      m_life [NREG];
  logic             m_pinned [NREG];
  logic             m_loop [NREG];
  logic [7:0]       m_spill [NREG];
  logic             m_recent [NREG];
  logic [15:0]      m_uses [NREG];
  logic [CNT_W-1:0] m_high;
  logic [CNT_W-1:0] m_avail;
  logic             m_reuse;

  alloc_req_t  pending_reqs[$];
  alloc_resp_t expected_resps[$];
  int fail_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int cycle_count = 0;

  function automatic void table_reset();
    for (int i = 0; i < NREG; i++) begin
      m_life[i] = '0;
      m_pinned[i] = (i < P_RESERVED);
      m_loop[i] = 1'b0;
      m_spill[i] = '0;
      m_recent[i] = 1'b0;
      m_uses[i] = '0;
    end
    m_high = '0;
    m_avail = CNT_W'(NREG - P_RESERVED);
    m_reuse = 1'b0;
  endfunction

  // Applies one request to the table and returns the response it produces.
  function automatic alloc_resp_t apply_request(alloc_req_t r);
    alloc_resp_t o;
    int best_score;
    int best;
    int score;
    int live;
    o.status = ST_DONE;
    o.chosen_reg = '0;
    case (r.command)
      CMD_ALLOC: begin
        best_score = -1;
        best = -1;
        for (int i = 0; i < NREG; i++) begin
          if (!m_pinned[i] && m_life[i] == 0) begin
            score = 100 - i / 4 + 10 - int'(m_spill[i]);
            if (r.is_loop && m_loop[i]) score += 20;
            if (m_reuse && m_recent[i]) score += 15;
            if (score > best_score) begin
              best_score = score;
              best = i;
            end
          end
        end
        if (best >= 0) begin
          m_life[best] = r.lifetime;
          m_loop[best] = r.is_loop;
          m_uses[best] = m_uses[best] + 16'd1;
          if (best + 1 > m_high) m_high = CNT_W'(best + 1);
          if (m_avail > 0) m_avail = m_avail - 1'b1;
          o.chosen_reg = 8'(best);
        end else begin
          o.status = ST_NONE;
        end
      end
      CMD_FREE: begin
        if (m_pinned[r.reg_index]) begin
          o.status = ST_PINNED;
        end else begin
          m_life[r.reg_index] = '0;
          m_recent[r.reg_index] = 1'b1;
          if (m_avail < NREG) m_avail = m_avail + 1'b1;
        end
      end
      CMD_LOOP: begin
        for (int i = 0; i < NREG; i++)
          if (m_life[i] != 0) m_loop[i] = 1'b1;
      end
      CMD_HOT: begin
        for (int i = 0; i < NREG && i < P_HOT_WINDOW; i++)
          if (m_life[i] != 0) m_spill[i] = '0;
      end
      CMD_SPILL: begin
        m_spill[r.reg_index] = r.spill_value;
      end
      default: ;
    endcase
    live = 0;
    for (int i = 0; i < NREG; i++)
      if (m_life[i] != 0) live++;
    o.high_water = m_high;
    o.free_count = m_avail;
    o.live_count = CNT_W'(live);
    return o;
  endfunction

  // Driver: presents queued requests, idling at random between them.
  always @(posedge clk) begin
    alloc_req_t r;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        r.command = in_command;
        r.reg_index = in_reg_index;
        r.is_loop = in_is_loop;
        r.lifetime = in_lifetime;
        r.spill_value = in_spill_value;
        expected_resps.push_back(apply_request(r));
      end
      if (!in_valid || !in_stall) begin
        if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          r = pending_reqs.pop_front();
          in_valid <= 1'b1;
          in_command <= r.command;
          in_reg_index <= r.reg_index;
          in_is_loop <= r.is_loop;
          in_lifetime <= r.lifetime;
          in_spill_value <= r.spill_value;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  task automatic check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $realtime, name, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Monitor: stalls at random and checks each accepted response.
  always @(posedge clk) begin
    alloc_resp_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_resps.size() == 0) begin
          $display("%0t: unexpected response, status %0d", $realtime, out_status);
          fail_count++;
        end else begin
          e = expected_resps.pop_front();
          check_field("status", e.status, out_status);
          check_field("chosen_reg", e.chosen_reg, out_chosen_reg);
          check_field("high_water", e.high_water, out_high_water);
          check_field("free_count", e.free_count, out_free_count);
          check_field("live_count", e.live_count, out_live_count);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("scored_register_allocator_top test failed");
      $finish;
    end
  end

  function automatic alloc_req_t make_req(logic [2:0] c, logic [7:0] idx, logic lp,
                                          logic [15:0] lt, logic [7:0] sv);
    alloc_req_t r;
    r.command = c;
    r.reg_index = idx;
    r.is_loop = lp;
    r.lifetime = lt;
    r.spill_value = sv;
    return r;
  endfunction

  // Random request with the given share of allocates and frees.
  function automatic alloc_req_t random_req(int alloc_pct, int free_pct);
    alloc_req_t r;
    int pick;
    int lt_pick;
    pick = $urandom_range(99);
    lt_pick = $urandom_range(9);
    r.reg_index = ($urandom_range(9) < 7) ? 8'($urandom_range(48)) : 8'($urandom);
    r.is_loop = 1'($urandom);
    r.lifetime = (lt_pick < 2) ? 16'd0 : (lt_pick == 2) ? 16'hFFFF : 16'($urandom);
    r.spill_value = ($urandom_range(3) == 0) ? 8'hFF : 8'($urandom);
    if (pick < alloc_pct) r.command = CMD_ALLOC;
    else if (pick < alloc_pct + free_pct) r.command = CMD_FREE;
    else begin
      case ($urandom_range(9))
        0, 1: r.command = CMD_LOOP;
        2, 3: r.command = CMD_HOT;
        4, 5, 6, 7: r.command = CMD_SPILL;
        default: r.command = 3'($urandom_range(7, 5));
      endcase
    end
    return r;
  endfunction

  // Checked between edges so that the driver's updates of this edge are settled.
  task automatic wait_idle();
    while (pending_reqs.size() > 0 || expected_resps.size() > 0 || in_valid)
      @(negedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reuse(logic v);
    cfg_valid <= 1'b1;
    cfg_reuse_enable <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    m_reuse = v;
    @(posedge clk);
  endtask

  initial begin
    table_reset();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part: pinned and zero-lifetime cases, negative scores, all commands.
    send_idle_pct = 15;
    recv_idle_pct = 74;
    write_reuse(1'b0);
    pending_reqs.push_back(make_req(CMD_SPILL, 8'd4, 1'b0, '0, 8'hFF));
    pending_reqs.push_back(make_req(CMD_ALLOC, 8'd0, 1'b0, 16'd1, '0));
    pending_reqs.push_back(make_req(CMD_ALLOC, 8'd0, 1'b0, 16'd0, '0));
    pending_reqs.push_back(make_req(CMD_ALLOC, 8'd0, 1'b0, 16'd0, '0));
    pending_reqs.push_back(make_req(CMD_ALLOC, 8'hFF, 1'b1, 16'hFFFF, 8'hFF));
    pending_reqs.push_back(make_req(CMD_FREE, 8'd0, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(CMD_FREE, 8'd3, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(CMD_FREE, 8'd5, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(CMD_FREE, 8'd200, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(CMD_FREE, 8'd255, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(CMD_LOOP, '0, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(CMD_HOT, '0, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(CMD_SPILL, 8'd0, 1'b0, '0, 8'hFF));
    pending_reqs.push_back(make_req(CMD_SPILL, 8'd6, 1'b0, '0, 8'd128));
    pending_reqs.push_back(make_req(CMD_SPILL, 8'd255, 1'b0, '0, 8'hFF));
    pending_reqs.push_back(make_req(CMD_ALLOC, 8'd0, 1'b1, 16'd7, '0));
    pending_reqs.push_back(make_req(3'd5, 8'hFF, 1'b1, 16'hFFFF, 8'hFF));
    pending_reqs.push_back(make_req(3'd6, '0, 1'b0, '0, '0));
    pending_reqs.push_back(make_req(3'd7, '0, 1'b0, '0, '0));
    for (int i = 0; i < 150; i++) pending_reqs.push_back(random_req(45, 35));
    wait_idle();

    // Reuse bonus on, heavy freeing drives the free count to its ceiling.
    send_idle_pct = 74;
    recv_idle_pct = 15;
    write_reuse(1'b1);
    for (int i = 0; i < 150; i++) pending_reqs.push_back(random_req(30, 55));
    wait_idle();

    // No idling; mostly allocates to exhaust the table.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    write_reuse(1'b0);
    for (int i = 0; i < 50; i++) pending_reqs.push_back(random_req(50, 30));
    wait_idle();
    write_reuse(1'b1);
    for (int i = 0; i < 230; i++) pending_reqs.push_back(random_req(92, 3));
    wait_idle();
    repeat (20) @(posedge clk);

    if (fail_count == 0) begin
      $display("scored_register_allocator_top test passed");
    end else begin
      $display("scored_register_allocator_top test failed");
    end
    $finish;
  end

endmodule
